### hw/rtl/setcnf_pkg.sv
// ----------------------------------------------------------------------------
// setcnf_pkg
// Shared types, token codes and the coordinate table for the set statement
// to CNF literal translator.
// ----------------------------------------------------------------------------
package setcnf_pkg;

   localparam int TokenWidth   = 6;
   localparam int LiteralWidth = 9;
   localparam int CoordWidth   = 5;
   localparam int QueueDepth   = 4;
   localparam int PtrWidth     = $clog2(QueueDepth);
   localparam int CountWidth   = $clog2(QueueDepth + 1);

   localparam logic [TokenWidth-1:0] TokEnd          = 6'd0;
   localparam logic [TokenWidth-1:0] TokRelIn        = 6'd32;
   localparam logic [TokenWidth-1:0] TokRelNotIn     = 6'd33;
   localparam logic [TokenWidth-1:0] TokRelLimit     = 6'd34;
   localparam logic [TokenWidth-1:0] TokOpUnion      = 6'd37;
   localparam logic [TokenWidth-1:0] TokOpIntersect  = 6'd38;
   localparam logic [TokenWidth-1:0] TokTableMax     = 6'd30;
   localparam logic [CoordWidth-1:0] RowMax          = 5'd11;

   typedef enum logic [7:0] {
      PH_OBJ     = 8'b0000_0001,
      PH_REL     = 8'b0000_0010,
      PH_TGT     = 8'b0000_0100,
      PH_OP      = 8'b0000_1000,
      PH_OPERAND = 8'b0001_0000,
      PH_GAP     = 8'b0010_0000,
      PH_DRAIN_S = 8'b0100_0000,
      PH_DRAIN_Q = 8'b1000_0000
   } phase_type;

   typedef enum logic [1:0] {
      POL_NONE    = 2'd0,
      POL_INCLUDE = 2'd1,
      POL_EXCLUDE = 2'd2
   } polarity_type;

   typedef struct packed {
      logic signed [LiteralWidth-1:0] literal;
      logic                           range_error;
      logic                           last;
   } result_type;

   // row/column coordinate of a table token (1..30)
   function automatic logic [CoordWidth-1:0] coord_of(input logic [TokenWidth-1:0] tok);
      logic [CoordWidth-1:0] c;
      case (tok)
         6'd1:    c = 5'd0;
         6'd2:    c = 5'd0;
         6'd3:    c = 5'd1;
         6'd4:    c = 5'd2;
         6'd5:    c = 5'd1;
         6'd6:    c = 5'd3;
         6'd7:    c = 5'd2;
         6'd8:    c = 5'd4;
         6'd9:    c = 5'd3;
         6'd10:   c = 5'd4;
         6'd11:   c = 5'd5;
         6'd12:   c = 5'd6;
         6'd13:   c = 5'd5;
         6'd14:   c = 5'd7;
         6'd15:   c = 5'd8;
         6'd16:   c = 5'd9;
         6'd17:   c = 5'd10;
         6'd18:   c = 5'd11;
         6'd19:   c = 5'd6;
         6'd20:   c = 5'd7;
         6'd21:   c = 5'd8;
         6'd22:   c = 5'd9;
         6'd23:   c = 5'd10;
         6'd24:   c = 5'd11;
         6'd25:   c = 5'd12;
         6'd26:   c = 5'd13;
         6'd27:   c = 5'd14;
         6'd28:   c = 5'd15;
         6'd29:   c = 5'd16;
         6'd30:   c = 5'd17;
         default: c = 5'd0;
      endcase
      return c;
   endfunction

   function automatic result_type separator();
      result_type r;
      r.literal     = '0;
      r.range_error = 1'b0;
      r.last        = 1'b0;
      return r;
   endfunction

   // literal for one operand: var = row*18 + col + 1, negated for exclusion
   function automatic result_type make_literal(input logic [TokenWidth-1:0] obj,
                                               input logic [TokenWidth-1:0] tgt,
                                               input polarity_type          pol);
      result_type                r;
      logic [CoordWidth-1:0]     row;
      logic [CoordWidth-1:0]     col;
      logic [LiteralWidth-1:0]   var_num;
      row = coord_of(tgt);
      col = coord_of(obj);
      var_num = {row, 4'b0000} + {3'b000, row, 1'b0} + {4'b0000, col} + 9'd1;
      r = separator();
      if (obj == TokEnd || obj > TokTableMax || tgt == TokEnd || tgt > TokTableMax ||
          row > RowMax) begin
         r.range_error = 1'b1;
      end else if (pol == POL_INCLUDE) begin
         r.literal = var_num;
      end else if (pol == POL_EXCLUDE) begin
         r.literal = 9'd0 - var_num;
      end
      return r;
   endfunction

endpackage

### hw/rtl/set_statement_to_cnf_literals_top.sv
// ----------------------------------------------------------------------------
// set_statement_to_cnf_literals_top
// Parses zero-terminated set statements token by token and emits signed
// CNF literals with clause separators.
//
// Usage:
//   req channel: one token per request (req_token, req_string_start); a set
//   string_start clears the parse state before its token is parsed.
//   rsp channel: zero, one or two results per token (rsp_literal,
//   rsp_range_error, rsp_last); rsp_last marks the final result of a token.
//   Results of a token are written to the result queue when it is taken.
//   Throughput: one token per cycle while req_ready is high; the parse state
//   is registered and results land in a four-entry result queue, so the rate
//   is set by the rsp side draining that queue (one result per cycle).
//   req_ready is high while the queue has room for two results, so tokens
//   keep flowing while a result waits to be taken.
//   Reset: parse state returns to waiting for an object, queue empties.
//   Stall: when rsp_ready is low the queue fills and req_ready drops; no
//   result is lost or repeated.
// ----------------------------------------------------------------------------
module set_statement_to_cnf_literals_top
   import setcnf_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [TokenWidth-1:0]          req_token,
   input  logic                           req_string_start,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [LiteralWidth-1:0] rsp_literal,
   output logic                           rsp_range_error,
   output logic                           rsp_last
);

   phase_type              phase_ff, phase_in, phase_cur;
   logic [TokenWidth-1:0]  object_ff, object_in, object_cur;
   logic [TokenWidth-1:0]  relation_ff, relation_in, relation_cur;
   logic [TokenWidth-1:0]  operator_ff, operator_in, operator_cur;
   polarity_type           polarity_ff, polarity_in, polarity_cur;

   result_type             queue_ff [QueueDepth];
   logic [PtrWidth-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0]  count_ff, count_in;

   logic                   req_fire;
   logic                   rsp_fire;
   logic [1:0]             push_num;
   result_type             res0, res1;
   result_type             head;

   assign req_ready = (count_ff <= CountWidth'(QueueDepth - 2));
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != '0);
   assign rsp_fire  = rsp_valid && rsp_ready;

   // parse step for one token
   always_comb begin
      if (req_string_start) begin
         phase_cur    = PH_OBJ;
         object_cur   = '0;
         relation_cur = '0;
         operator_cur = '0;
         polarity_cur = POL_NONE;
      end else begin
         phase_cur    = phase_ff;
         object_cur   = object_ff;
         relation_cur = relation_ff;
         operator_cur = operator_ff;
         polarity_cur = polarity_ff;
      end

      phase_in    = phase_cur;
      object_in   = object_cur;
      relation_in = relation_cur;
      operator_in = operator_cur;
      polarity_in = polarity_cur;
      push_num    = 2'd0;
      res0        = separator();
      res1        = separator();

      unique case (phase_cur)
         PH_OBJ: begin
            if (req_token != TokEnd) begin
               object_in = req_token;
               phase_in  = PH_REL;
            end
         end
         PH_REL: begin
            if (req_token != TokEnd) begin
               relation_in = req_token;
               phase_in    = PH_TGT;
            end
         end
         PH_TGT: begin
            if (req_token == TokEnd) begin
               phase_in    = PH_OBJ;
               object_in   = '0;
               relation_in = '0;
               operator_in = '0;
               polarity_in = POL_NONE;
            end else if (relation_cur >= TokRelLimit) begin
               phase_in = PH_DRAIN_Q;
            end else begin
               polarity_in = (relation_cur == TokRelIn)    ? POL_INCLUDE :
                             (relation_cur == TokRelNotIn) ? POL_EXCLUDE : POL_NONE;
               res0     = make_literal(object_cur, req_token, polarity_in);
               push_num = 2'd1;
               phase_in = PH_OP;
            end
         end
         PH_OP: begin
            if (req_token == TokEnd) begin
               push_num    = 2'd1;
               phase_in    = PH_OBJ;
               object_in   = '0;
               relation_in = '0;
               operator_in = '0;
               polarity_in = POL_NONE;
            end else begin
               operator_in = req_token;
               phase_in    = (req_token == TokOpUnion || req_token == TokOpIntersect) ?
                             PH_OPERAND : PH_DRAIN_S;
            end
         end
         PH_OPERAND: begin
            if (req_token == TokEnd) begin
               push_num    = 2'd1;
               phase_in    = PH_OBJ;
               object_in   = '0;
               relation_in = '0;
               operator_in = '0;
               polarity_in = POL_NONE;
            end else begin
               // de morgan split puts a separator ahead of the literal
               if ((operator_cur == TokOpUnion && polarity_cur == POL_EXCLUDE) ||
                   (operator_cur == TokOpIntersect && polarity_cur == POL_INCLUDE)) begin
                  res1     = make_literal(object_cur, req_token, polarity_cur);
                  push_num = 2'd2;
               end else begin
                  res0     = make_literal(object_cur, req_token, polarity_cur);
                  push_num = 2'd1;
               end
               phase_in = PH_GAP;
            end
         end
         PH_GAP, PH_DRAIN_S: begin
            if (req_token == TokEnd) begin
               push_num    = 2'd1;
               phase_in    = PH_OBJ;
               object_in   = '0;
               relation_in = '0;
               operator_in = '0;
               polarity_in = POL_NONE;
            end else if (phase_cur == PH_GAP) begin
               phase_in = PH_OPERAND;
            end
         end
         PH_DRAIN_Q: begin
            if (req_token == TokEnd) begin
               phase_in    = PH_OBJ;
               object_in   = '0;
               relation_in = '0;
               operator_in = '0;
               polarity_in = POL_NONE;
            end
         end
         default: begin
            phase_in    = PH_OBJ;
            object_in   = '0;
            relation_in = '0;
            operator_in = '0;
            polarity_in = POL_NONE;
         end
      endcase

      if (push_num == 2'd1) begin
         res0.last = 1'b1;
      end else if (push_num == 2'd2) begin
         res1.last = 1'b1;
      end
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_fire) begin
         wr_ptr_in = wr_ptr_ff + PtrWidth'(push_num);
         count_in  = count_in + CountWidth'(push_num);
      end
      if (rsp_fire) begin
         rd_ptr_in = rd_ptr_ff + PtrWidth'(1);
         count_in  = count_in - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_OBJ;
         object_ff   <= '0;
         relation_ff <= '0;
         operator_ff <= '0;
         polarity_ff <= POL_NONE;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         count_ff    <= '0;
      end else begin
         if (req_fire) begin
            phase_ff    <= phase_in;
            object_ff   <= object_in;
            relation_ff <= relation_in;
            operator_ff <= operator_in;
            polarity_ff <= polarity_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // result queue storage
   always_ff @(posedge clock) begin
      if (req_fire && push_num != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (req_fire && push_num == 2'd2) begin
         queue_ff[wr_ptr_ff + PtrWidth'(1)] <= res1;
      end
   end

   assign head            = queue_ff[rd_ptr_ff];
   assign rsp_literal     = head.literal;
   assign rsp_range_error = head.range_error;
   assign rsp_last        = head.last;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QueueDepth))
      else $error("result queue count above depth");

   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> count_ff == '0)
      else $error("result queue not empty after reset");

   a_pair_sep_first: assert property (@(posedge clock) disable iff (reset)
      (req_fire && push_num == 2'd2) |-> (res0.literal == '0 && !res0.range_error))
      else $error("two results from a token without a leading separator");

   a_drain_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && phase_cur == PH_DRAIN_Q) |-> push_num == 2'd0)
      else $error("result produced while draining an unfinished statement");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (!req_fire && !rsp_fire) |=> $stable(count_ff))
      else $error("queue count moved without a handshake");

endmodule
